FILE: src/prfo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prfo_pkg;

    localparam int RING_DEPTH       = 8192;
    localparam int MAX_PACKET_BYTES = 4096;

    localparam int SIZE_W  = 13;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 14;
    localparam int BYTES_W = 26;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } desc_t;

    typedef struct packed {
        logic               popped_valid;
        logic               overwrote_oldest;
        logic [SIZE_W-1:0]  size_out;
        logic [TAG_W-1:0]   tag_out;
        logic [COUNT_W-1:0] held_packets;
        logic [BYTES_W-1:0] held_bytes;
    } result_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } back_state_t;

endpackage

`default_nettype wire

FILE: src/prfo_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface prfo_in_if
    import prfo_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [SIZE_W-1:0] pkt_size;
    logic [TAG_W-1:0]  packet_tag;

    modport source (output valid, output mode, output pkt_size, output packet_tag,
                    input ready);
    modport sink (input valid, input mode, input pkt_size, input packet_tag,
                  output ready);
endinterface

interface prfo_out_if
    import prfo_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               popped_valid;
    logic               overwrote_oldest;
    logic [SIZE_W-1:0]  size_out;
    logic [TAG_W-1:0]   tag_out;
    logic [COUNT_W-1:0] held_packets;
    logic [BYTES_W-1:0] held_bytes;

    modport source (output valid, output popped_valid, output overwrote_oldest,
                    output size_out, output tag_out, output held_packets,
                    output held_bytes, input ready);
    modport sink (input valid, input popped_valid, input overwrote_oldest,
                  input size_out, input tag_out, input held_packets,
                  input held_bytes, output ready);
endinterface

`default_nettype wire

FILE: src/packet_ring_fifo_overwrite.sv
// Packet descriptor FIFO that overwrites its oldest entry when full.
// The item channel takes one beat per command: mode 0 pushes a descriptor
// (pkt_size, packet_tag), mode 1 pops the oldest one. Sizes above the
// maximum packet size are clamped. The result channel returns exactly one
// beat per command, in order, with the popped descriptor (or zeros), the
// overwrite flag, and the packet count and byte total after the command.
// A command passes from the two-beat queue to a read state, in which
// the descriptor memory is read, and then to an execute state, in which
// the memory is written and the result beat is registered, so the
// sequencer finishes one command before it takes the next. The queue
// decouples the item channel from the execution sequencer, so commands
// are still taken while a result waits. When the result receiver stalls,
// the sequencer holds its command and the queue fills, after which item
// ready drops. Reset clears the head, the count and the byte total; the
// descriptor memory is not cleared; its slots are used only once written.
`timescale 1ns / 1ps
`default_nettype none

module packet_ring_fifo_overwrite
    import prfo_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    prfo_in_if.sink     item,
    prfo_out_if.source  result
);

    logic   q_valid;
    logic   q_ready;
    desc_t  q_item;

    prfo_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready)
    );

    prfo_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_ready (q_ready),
        .result  (result)
    );

endmodule

`default_nettype wire

FILE: src/prfo_front.sv
`timescale 1ns / 1ps
`default_nettype none

module prfo_front
    import prfo_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    prfo_in_if.sink     item,
    output      logic   q_valid,
    output      desc_t  q_item,
    input  wire logic   q_ready
);

    desc_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        push_en;
    logic        pop_en;
    desc_t       entry;

    // Oversized packets are clamped before they reach the store.
    always_comb
    begin
        unique case (item.mode)
            1'b0: entry.op = OP_PUSH;
            1'b1: entry.op = OP_POP;
            default: entry.op = OP_PUSH;
        endcase
        if (item.pkt_size > SIZE_W'(MAX_PACKET_BYTES))
        begin
            entry.size = SIZE_W'(MAX_PACKET_BYTES);
        end
        else
        begin
            entry.size = item.pkt_size;
        end
        entry.tag = item.packet_tag;
    end

    assign item.ready = (fill_reg != 2'd2);
    assign push_en    = item.valid && item.ready;
    assign q_valid    = (fill_reg != 2'd0);
    assign q_item     = slot_reg[rd_ptr_reg];
    assign pop_en     = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_en ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push_en) - 2'(pop_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

`default_nettype wire

FILE: src/prfo_back.sv
`timescale 1ns / 1ps
`default_nettype none

module prfo_back
    import prfo_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    input  wire desc_t  q_item,
    output      logic   q_ready,
    prfo_out_if.source  result
);

    logic [SIZE_W+TAG_W-1:0] ring_mem [RING_DEPTH];
    logic [SIZE_W+TAG_W-1:0] rd_data_reg;

    back_state_t         state_reg;
    back_state_t         state_next;
    desc_t               op_reg;
    logic [ADDR_W-1:0]   head_reg;
    logic [ADDR_W-1:0]   head_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [BYTES_W-1:0]  bytes_next;
    logic                res_valid_reg;
    logic                res_valid_next;
    result_t             res_reg;
    result_t             res_next;

    logic                rd_en;
    logic                exec_fire;
    logic                wr_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [CNT_W-1:0]    head_ext;
    logic                full;
    logic [SIZE_W-1:0]   slot_size;
    logic [TAG_W-1:0]    old_tag;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_valid) state_next = ST_EXEC;
            ST_EXEC: if (!res_valid_reg || result.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_ready   = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: q_ready = 1'b1;
            ST_EXEC: exec_fire = !res_valid_reg || result.ready;
            default: q_ready = 1'b0;
        endcase
    end

    assign rd_en     = q_valid && q_ready;
    assign head_ext  = CNT_W'(head_reg);
    assign full      = (count_reg == CNT_W'(RING_DEPTH));
    assign slot_size = rd_data_reg[SIZE_W-1:0];
    assign old_tag   = rd_data_reg[SIZE_W+TAG_W-1:SIZE_W];

    // A push reads the slot at the head, which holds the oldest entry when full.
    always_comb
    begin
        if (q_item.op == OP_PUSH)
        begin
            rd_addr = head_reg;
        end
        else if (head_ext >= count_reg)
        begin
            rd_addr = ADDR_W'(head_ext - count_reg);
        end
        else
        begin
            rd_addr = ADDR_W'(head_ext + CNT_W'(RING_DEPTH) - count_reg);
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        bytes_next = bytes_reg;
        wr_en      = 1'b0;
        res_next   = res_reg;
        if (exec_fire)
        begin
            res_next.popped_valid     = 1'b0;
            res_next.overwrote_oldest = 1'b0;
            res_next.size_out         = '0;
            res_next.tag_out          = '0;
            unique case (op_reg.op)
                OP_PUSH:
                begin
                    wr_en = 1'b1;
                    if (head_reg == ADDR_W'(RING_DEPTH - 1))
                    begin
                        head_next = '0;
                    end
                    else
                    begin
                        head_next = head_reg + ADDR_W'(1);
                    end
                    if (full)
                    begin
                        res_next.overwrote_oldest = 1'b1;
                        bytes_next = bytes_reg + BYTES_W'(op_reg.size)
                                     - BYTES_W'(slot_size);
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        bytes_next = bytes_reg + BYTES_W'(op_reg.size);
                    end
                end
                OP_POP:
                begin
                    if (count_reg != '0)
                    begin
                        res_next.popped_valid = 1'b1;
                        res_next.size_out     = slot_size;
                        res_next.tag_out      = old_tag;
                        count_next = count_reg - CNT_W'(1);
                        bytes_next = bytes_reg - BYTES_W'(slot_size);
                    end
                end
                default: wr_en = 1'b0;
            endcase
            res_next.held_packets = COUNT_W'(count_next);
            res_next.held_bytes   = bytes_next;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (exec_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            bytes_reg     <= bytes_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (rd_en)
        begin
            op_reg <= q_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[head_reg] <= {op_reg.tag, op_reg.size};
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.popped_valid     = res_reg.popped_valid;
    assign result.overwrote_oldest = res_reg.overwrote_oldest;
    assign result.size_out         = res_reg.size_out;
    assign result.tag_out          = res_reg.tag_out;
    assign result.held_packets     = res_reg.held_packets;
    assign result.held_bytes       = res_reg.held_bytes;

endmodule

`default_nettype wire

FILE: src/prfo_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module prfo_checker
    import prfo_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_ready,
    input wire logic               res_valid,
    input wire logic               res_ready,
    input wire logic               popped_valid,
    input wire logic               overwrote_oldest,
    input wire logic [SIZE_W-1:0]  size_out,
    input wire logic [TAG_W-1:0]   tag_out,
    input wire logic [COUNT_W-1:0] held_packets
);

    logic [3:0] pending_reg;
    logic [3:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg + 4'(item_valid && item_ready)
                       - 4'(res_valid && res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 4'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A result beat always belongs to a command that was taken earlier.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (pending_reg != 4'd0))
        else $error("result beat without an outstanding command");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(popped_valid && overwrote_oldest))
        else $error("pop and overwrite flagged on the same beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !popped_valid) |-> (size_out == '0 && tag_out == '0))
        else $error("descriptor fields not zero without a pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && overwrote_oldest) |-> (held_packets == COUNT_W'(RING_DEPTH)))
        else $error("overwrite reported while the ring was not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (held_packets <= COUNT_W'(RING_DEPTH)))
        else $error("packet count above ring depth");

endmodule

bind packet_ring_fifo_overwrite prfo_checker u_prfo_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .popped_valid     (result.popped_valid),
    .overwrote_oldest (result.overwrote_oldest),
    .size_out         (result.size_out),
    .tag_out          (result.tag_out),
    .held_packets     (result.held_packets)
);

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import prfo_pkg::*;

    localparam int LONG_STALL  = 400;
    localparam int IDLE_PCT    = 19;
    localparam int TAIL_CYCLES = 8;

    typedef struct {
        op_t               op;
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
        bit                typed;
        result_t           want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    prfo_in_if  item_if ();
    prfo_out_if result_if ();

    packet_ring_fifo_overwrite u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [SIZE_W+TAG_W-1:0] ring_mem [RING_DEPTH];
    int unsigned             ring_head;
    int unsigned             ring_count;
    logic [BYTES_W-1:0]      ring_bytes;

    result_t     due_results [$];
    stim_row_t   directed_rows [19];
    int          mismatches;
    int          beats_checked;
    int          pushes;
    int          pops;
    int          overwrites;
    int          empty_pops;
    int unsigned deepest_fill;
    bit          calm;
    bit          stall_request;

    function automatic result_t ring_predict(input op_t op, input logic [SIZE_W-1:0] size,
                                             input logic [TAG_W-1:0] tag);
        result_t                 r;
        logic [SIZE_W-1:0]       clamped;
        logic [SIZE_W-1:0]       lost;
        logic [SIZE_W+TAG_W-1:0] entry;
        int unsigned             tail;
        r = '0;
        if (op == OP_PUSH)
        begin
            clamped = (size > MAX_PACKET_BYTES) ? SIZE_W'(MAX_PACKET_BYTES) : size;
            if (ring_count < RING_DEPTH)
            begin
                ring_count++;
                ring_bytes = ring_bytes + clamped;
            end
            else
            begin
                lost = ring_mem[ring_head][SIZE_W-1:0];
                r.overwrote_oldest = 1'b1;
                ring_bytes = ring_bytes + clamped - lost;
            end
            ring_mem[ring_head] = {tag, clamped};
            ring_head = (ring_head + 1) % RING_DEPTH;
        end
        else if (ring_count > 0)
        begin
            tail = (ring_head + RING_DEPTH - ring_count) % RING_DEPTH;
            entry = ring_mem[tail];
            r.popped_valid = 1'b1;
            r.size_out = entry[SIZE_W-1:0];
            r.tag_out = entry[SIZE_W+TAG_W-1:SIZE_W];
            ring_count--;
            ring_bytes = ring_bytes - entry[SIZE_W-1:0];
        end
        r.held_packets = COUNT_W'(ring_count);
        r.held_bytes = ring_bytes;
        return r;
    endfunction

    task automatic offer_beat(input op_t op, input logic [SIZE_W-1:0] size,
                              input logic [TAG_W-1:0] tag, input bit typed, input result_t want);
        result_t predicted;
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.mode <= op;
        item_if.pkt_size <= size;
        item_if.packet_tag <= tag;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        predicted = ring_predict(op, size, tag);
        due_results.push_back(typed ? want : predicted);
        if (op == OP_PUSH)
        begin
            pushes++;
            overwrites += predicted.overwrote_oldest;
        end
        else
        begin
            pops++;
            empty_pops += !predicted.popped_valid;
        end
        if (ring_count > deepest_fill)
            deepest_fill = ring_count;
    endtask

    task automatic offer_random(input int push_pct);
        op_t               op;
        logic [SIZE_W-1:0] size;
        op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
        size = ($urandom_range(99) < 85) ? SIZE_W'($urandom_range(MAX_PACKET_BYTES))
                                         : SIZE_W'($urandom_range((1 << SIZE_W) - 1));
        offer_beat(op, size, TAG_W'($urandom), 1'b0, '0);
    endtask

    task automatic wait_drained();
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            got = {result_if.popped_valid, result_if.overwrote_oldest, result_if.size_out,
                   result_if.tag_out, result_if.held_packets, result_if.held_bytes};
            if (due_results.size() == 0)
            begin
                $error("result beat arrived with no command outstanding");
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                beats_checked++;
                match_field("popped_valid", want.popped_valid, got.popped_valid);
                match_field("overwrote_oldest", want.overwrote_oldest, got.overwrote_oldest);
                match_field("size_out", want.size_out, got.size_out);
                match_field("tag_out", want.tag_out, got.tag_out);
                match_field("held_packets", want.held_packets, got.held_packets);
                match_field("held_bytes", want.held_bytes, got.held_bytes);
            end
        end
    end

    initial
    begin
        result_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (stall_request)
            begin
                result_if.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                stall_request = 1'b0;
            end
            else
            begin
                result_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        item_if.valid = 1'b0;
        item_if.mode = OP_PUSH;
        item_if.pkt_size = '0;
        item_if.packet_tag = '0;
        ring_head = 0;
        ring_count = 0;
        ring_bytes = '0;
        calm = 1'b0;
        stall_request = 1'b0;
        directed_rows = '{
            '{OP_POP,  13'd0,    16'h0000, 1'b1, result_t'{1'b0, 1'b0, 13'd0, 16'h0000, 14'd0, 26'd0}},
            '{OP_PUSH, 13'd0,    16'h0000, 1'b1, result_t'{1'b0, 1'b0, 13'd0, 16'h0000, 14'd1, 26'd0}},
            '{OP_PUSH, 13'd4096, 16'hFFFF, 1'b1,
              result_t'{1'b0, 1'b0, 13'd0, 16'h0000, 14'd2, 26'd4096}},
            '{OP_PUSH, 13'd8191, 16'hAAAA, 1'b1,
              result_t'{1'b0, 1'b0, 13'd0, 16'h0000, 14'd3, 26'd8192}},
            '{OP_PUSH, 13'd4097, 16'h5555, 1'b1,
              result_t'{1'b0, 1'b0, 13'd0, 16'h0000, 14'd4, 26'd12288}},
            '{OP_PUSH, 13'd1,    16'h0001, 1'b0, '0},
            '{OP_POP,  13'd0,    16'h0000, 1'b1,
              result_t'{1'b1, 1'b0, 13'd0, 16'h0000, 14'd4, 26'd12289}},
            '{OP_POP,  13'd8191, 16'hFFFF, 1'b1,
              result_t'{1'b1, 1'b0, 13'd4096, 16'hFFFF, 14'd3, 26'd8193}},
            '{OP_POP,  13'd0,    16'h0000, 1'b1,
              result_t'{1'b1, 1'b0, 13'd4096, 16'hAAAA, 14'd2, 26'd4097}},
            '{OP_POP,  13'd0,    16'h0000, 1'b1,
              result_t'{1'b1, 1'b0, 13'd4096, 16'h5555, 14'd1, 26'd1}},
            '{OP_POP,  13'd0,    16'h0000, 1'b1,
              result_t'{1'b1, 1'b0, 13'd1, 16'h0001, 14'd0, 26'd0}},
            '{OP_POP,  13'd1234, 16'h1234, 1'b1, result_t'{1'b0, 1'b0, 13'd0, 16'h0000, 14'd0, 26'd0}},
            '{OP_PUSH, 13'h0AAA, 16'hA5A5, 1'b0, '0},
            '{OP_PUSH, 13'h0555, 16'h5A5A, 1'b0, '0},
            '{OP_POP,  13'd0,    16'h0000, 1'b0, '0},
            '{OP_PUSH, 13'h1000, 16'h8000, 1'b0, '0},
            '{OP_POP,  13'd0,    16'h0000, 1'b0, '0},
            '{OP_POP,  13'd0,    16'h0000, 1'b0, '0},
            '{OP_POP,  13'd0,    16'h0000, 1'b0, '0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_beat(directed_rows[i].op, directed_rows[i].size, directed_rows[i].tag,
                       directed_rows[i].typed, directed_rows[i].want);

        repeat (250) offer_random(55);

        // The result side holds off while commands keep coming, so the input must stall.
        stall_request = 1'b1;
        repeat (60) offer_random(70);

        item_if.valid <= 1'b0;
        wait_drained();

        // A long stretch with no idle cycles on either side.
        calm = 1'b1;
        repeat (150) offer_random(60);
        calm = 1'b0;

        repeat (200) offer_random(50);

        item_if.valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d commands: %0d pushes (%0d overwriting the oldest beat), %0d pops",
                 pushes + pops, pushes, overwrites, pops);
        $display("(%0d on an empty ring); %0d result beats checked, deepest fill %0d packets.",
                 empty_pops, beats_checked, deepest_fill);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
src/prfo_pkg.sv
src/prfo_if.sv
src/prfo_front.sv
src/prfo_back.sv
src/packet_ring_fifo_overwrite.sv
src/prfo_checker.sv
test/tb.sv
